// ===== src/gpio_port_with_edge_level_interrupts_core_assert.svh =====
// Assertion macros for the GPIO port core.
// Each macro checks a property on the rising edge of i_clk.
// Checks are switched off while the reset is held.
`ifndef GPIO_PORT_WITH_EDGE_LEVEL_INTERRUPTS_CORE_ASSERT_SVH
`define GPIO_PORT_WITH_EDGE_LEVEL_INTERRUPTS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPIOEI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPIOEI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/gpioei_pkg.sv =====
package gpioei_pkg;

    // Number of pins in use; the upper bits of every byte read as zero.
    localparam int PIN_COUNT = 8;
    localparam logic [7:0] PIN_MASK = 8'((1 << PIN_COUNT) - 1);

    // Request kinds. The fourth code is unused and leaves the port alone.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    // Register word offsets in the 4 KB window.
    localparam logic [9:0] OFF_DIR   = 10'd256;
    localparam logic [9:0] OFF_IS    = 10'd257;
    localparam logic [9:0] OFF_IBE   = 10'd258;
    localparam logic [9:0] OFF_IEV   = 10'd259;
    localparam logic [9:0] OFF_IE    = 10'd260;
    localparam logic [9:0] OFF_RIS   = 10'd261;
    localparam logic [9:0] OFF_MIS   = 10'd262;
    localparam logic [9:0] OFF_IC    = 10'd263;
    localparam logic [9:0] OFF_AFSEL = 10'd264;

    // Identification bytes occupy the last eight words of the window.
    localparam logic [6:0] ID_PAGE = 7'd127;

    // One request as it sits in the input register.
    typedef struct packed {
        logic [1:0] func;
        logic [9:0] addr;
        logic [7:0] wdata;
        logic [7:0] pins;
    } t_req;

    // Port state after a request, as shown with every result.
    typedef struct packed {
        logic [7:0] out_data;
        logic [7:0] direction;
        logic [7:0] alt_function;
        logic [7:0] irq_lines;
    } t_port_status;

    // Peripheral and cell identification bytes.
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h61;
            3'd1:    v = 8'h10;
            3'd2:    v = 8'h04;
            3'd3:    v = 8'h00;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'hF0;
            3'd6:    v = 8'h05;
            default: v = 8'hB1;
        endcase
        return v;
    endfunction

endpackage

// ===== src/gpio_port_with_edge_level_interrupts_core.sv =====
// Eight-pin GPIO port with edge and level interrupt detection.
// Input channel: one request per accepted i_in_valid without o_in_stall:
// i_func selects a pin sample tick, a bus read or a bus write; i_addr is
// the word offset (0..255 is the masked data window), i_wdata the write
// byte and i_pins_in the current pin levels.
// Output channel: exactly one result per request, in order, on o_out_valid,
// held while i_out_stall is high. It carries the read byte (zero for ticks
// and writes) and the pin drive, output enable, alternate select and masked
// interrupt state after the request.
// A request is first held in the input register, then the decode and per-pin
// logic load the result register once it is free. One request per cycle is
// sustained while i_out_stall is low; all per-pin logic is bitwise, so the
// single pass sets the rate.
// When the receiver stalls, the result register holds and the input
// register fills; o_in_stall rises only when both are occupied.
// Reset empties both pipeline registers and clears every port register to
// zero: all pins are inputs, edge sensing on falling edges, interrupts disabled.
module gpio_port_with_edge_level_interrupts_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [9:0] i_addr,
    input  logic [7:0] i_wdata,
    input  logic [7:0] i_pins_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_rdata,
    output logic [7:0] o_pins_out,
    output logic [7:0] o_pins_oe,
    output logic [7:0] o_alt_select,
    output logic [7:0] o_irq_lines,
    output logic       o_irq_any
);
    import gpioei_pkg::*;

`include "gpio_port_with_edge_level_interrupts_core_assert.svh"

    logic         r_in_valid;
    t_req         r_req;
    logic         r_out_valid;
    logic [7:0]   r_rdata;
    t_port_status r_status;

    logic         out_free;
    logic         advance;
    logic         in_accept;
    logic [7:0]   rdata;
    t_port_status status;

    // Handshake: the result register frees up when empty or being taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.func  <= i_func;
            r_req.addr  <= i_addr;
            r_req.wdata <= i_wdata & PIN_MASK;
            r_req.pins  <= i_pins_in & PIN_MASK;
        end
    end

    // Register bank and request decode.
    gpioei_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_req    (r_req),
        .o_rdata  (rdata),
        .o_status (status)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rdata  <= rdata;
            r_status <= status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rdata      = r_rdata;
    assign o_pins_out   = r_status.out_data;
    assign o_pins_oe    = r_status.direction;
    assign o_alt_select = r_status.alt_function;
    assign o_irq_lines  = r_status.irq_lines;
    assign o_irq_any    = |r_status.irq_lines;

    // A request leaving the input register always lands in the result register.
    `GPIOEI_ASSERT_NEXT(a_advance_fills_result, advance, o_out_valid, "request lost after advance")

    // Nothing can be accepted while the input register is held up.
    `GPIOEI_ASSERT_SAME(a_no_accept_when_full, r_in_valid && !out_free, !in_accept, "accept while full")

    // Results never drive pins beyond the pin count.
    `GPIOEI_ASSERT_SAME(a_pins_in_range, o_out_valid, ((o_pins_out | o_pins_oe | o_irq_lines) & ~PIN_MASK) == 8'd0, "unused pin driven")

endmodule

// ===== src/gpioei_detect.sv =====
module gpioei_detect (
    input  logic [7:0] i_prev_pins,
    input  logic [7:0] i_pins,
    input  logic [7:0] i_both_edges,
    input  logic [7:0] i_event_polarity,
    input  logic [7:0] i_sense_level,
    input  logic [7:0] i_raw_status,
    output logic [7:0] o_raw_status
);
    import gpioei_pkg::*;

    logic [7:0] rise;
    logic [7:0] fall;
    logic [7:0] edge_hit;
    logic [7:0] level_hit;
    logic [7:0] edge_bits;

    // Rising and falling edges against the previous sample.
    assign rise = ~i_prev_pins & i_pins;
    assign fall = i_prev_pins & ~i_pins;

    // Both-edge pins take either edge, the others the edge their polarity picks.
    assign edge_hit = (i_both_edges & (rise | fall)) |
                      (~i_both_edges & ((i_event_polarity & rise) |
                                        (~i_event_polarity & fall)));

    // A level-sensed pin is active while it matches its polarity.
    assign level_hit = ~(i_pins ^ i_event_polarity);

    // Edge bits are sticky; level bits follow the pin on every sample.
    assign edge_bits    = (i_raw_status | edge_hit) & ~i_sense_level;
    assign o_raw_status = (edge_bits | (level_hit & i_sense_level)) & PIN_MASK;

endmodule

// ===== src/gpioei_regs.sv =====
module gpioei_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  gpioei_pkg::t_req         i_req,
    output logic [7:0]               o_rdata,
    output gpioei_pkg::t_port_status o_status
);
    import gpioei_pkg::*;

    logic [7:0] r_out_data,       n_out_data;
    logic [7:0] r_direction,      n_direction;
    logic [7:0] r_sense_level,    n_sense_level;
    logic [7:0] r_both_edges,     n_both_edges;
    logic [7:0] r_event_polarity, n_event_polarity;
    logic [7:0] r_int_enable,     n_int_enable;
    logic [7:0] r_raw_status,     n_raw_status;
    logic [7:0] r_alt_function,   n_alt_function;
    logic [7:0] r_prev_pins,      n_prev_pins;

    logic [7:0] sampled_raw;
    logic       in_window;
    logic [7:0] window_mask;

    assign in_window   = (i_req.addr[9:8] == 2'd0);
    assign window_mask = i_req.addr[7:0] & PIN_MASK;

    // Interrupt detection on the sampled pin levels.
    gpioei_detect u_detect (
        .i_prev_pins      (r_prev_pins),
        .i_pins           (i_req.pins),
        .i_both_edges     (r_both_edges),
        .i_event_polarity (r_event_polarity),
        .i_sense_level    (r_sense_level),
        .i_raw_status     (r_raw_status),
        .o_raw_status     (sampled_raw)
    );

    // Next state for a sample tick or a register write.
    always_comb begin
        n_out_data       = r_out_data;
        n_direction      = r_direction;
        n_sense_level    = r_sense_level;
        n_both_edges     = r_both_edges;
        n_event_polarity = r_event_polarity;
        n_int_enable     = r_int_enable;
        n_raw_status     = r_raw_status;
        n_alt_function   = r_alt_function;
        n_prev_pins      = r_prev_pins;
        if (i_req.func == FUNC_TICK) begin
            n_raw_status = sampled_raw;
            n_prev_pins  = i_req.pins;
        end else if (i_req.func == FUNC_WRITE) begin
            if (in_window) begin
                n_out_data = (r_out_data & ~window_mask) | (i_req.wdata & window_mask);
            end else begin
                unique case (i_req.addr)
                    OFF_DIR:   n_direction      = i_req.wdata;
                    OFF_IS:    n_sense_level    = i_req.wdata;
                    OFF_IBE:   n_both_edges     = i_req.wdata;
                    OFF_IEV:   n_event_polarity = i_req.wdata;
                    OFF_IE:    n_int_enable     = i_req.wdata;
                    OFF_IC:    n_raw_status     = r_raw_status &
                                                  ~(i_req.wdata & ~r_sense_level);
                    OFF_AFSEL: n_alt_function   = i_req.wdata;
                    default:   n_raw_status     = r_raw_status;
                endcase
            end
        end
    end

    // Read data comes from the state before the request.
    always_comb begin
        o_rdata = 8'd0;
        if (i_req.func == FUNC_READ) begin
            if (in_window) begin
                o_rdata = ((r_out_data & r_direction) | (i_req.pins & ~r_direction)) &
                          window_mask;
            end else begin
                unique case (i_req.addr)
                    OFF_DIR:   o_rdata = r_direction;
                    OFF_IS:    o_rdata = r_sense_level;
                    OFF_IBE:   o_rdata = r_both_edges;
                    OFF_IEV:   o_rdata = r_event_polarity;
                    OFF_IE:    o_rdata = r_int_enable;
                    OFF_RIS:   o_rdata = r_raw_status;
                    OFF_MIS:   o_rdata = r_raw_status & r_int_enable;
                    OFF_AFSEL: o_rdata = r_alt_function;
                    default: begin
                        if (i_req.addr[9:3] == ID_PAGE) begin
                            o_rdata = id_byte(i_req.addr[2:0]);
                        end
                    end
                endcase
            end
        end
    end

    // State shown with the result is the state after the request.
    assign o_status.out_data     = n_out_data & PIN_MASK;
    assign o_status.direction    = n_direction & PIN_MASK;
    assign o_status.alt_function = n_alt_function & PIN_MASK;
    assign o_status.irq_lines    = n_raw_status & n_int_enable & PIN_MASK;

    // Register bank, updated when the request moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_data       <= 8'd0;
            r_direction      <= 8'd0;
            r_sense_level    <= 8'd0;
            r_both_edges     <= 8'd0;
            r_event_polarity <= 8'd0;
            r_int_enable     <= 8'd0;
            r_raw_status     <= 8'd0;
            r_alt_function   <= 8'd0;
            r_prev_pins      <= 8'd0;
        end else if (i_en) begin
            r_out_data       <= n_out_data;
            r_direction      <= n_direction;
            r_sense_level    <= n_sense_level;
            r_both_edges     <= n_both_edges;
            r_event_polarity <= n_event_polarity;
            r_int_enable     <= n_int_enable;
            r_raw_status     <= n_raw_status;
            r_alt_function   <= n_alt_function;
            r_prev_pins      <= n_prev_pins;
        end
    end

endmodule
